// File: src/tcv_pkg.sv
// Shared types, codes and helpers for the transposed convolution engine.
// No dependencies; the files that use it refer to it by scoped names.
package tcv_pkg;

  localparam logic [2:0] KIND_WEIGHT = 3'd0;
  localparam logic [2:0] KIND_BIAS   = 3'd1;
  localparam logic [2:0] KIND_ELEM   = 3'd2;
  localparam logic [2:0] KIND_READ   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  localparam logic [3:0] REG_OUT_HEIGHT    = 4'd0;
  localparam logic [3:0] REG_OUT_WIDTH     = 4'd1;
  localparam logic [3:0] REG_STRIDE_ROWS   = 4'd2;
  localparam logic [3:0] REG_STRIDE_COLS   = 4'd3;
  localparam logic [3:0] REG_DILATION_ROWS = 4'd4;
  localparam logic [3:0] REG_DILATION_COLS = 4'd5;
  localparam logic [3:0] REG_PAD_TOP       = 4'd6;
  localparam logic [3:0] REG_PAD_LEFT      = 4'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         in_channel;
    logic [1:0]         out_map;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] result_value;
    logic               out_of_range;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] wdata;
  } cfg_write_t;

  typedef struct packed {
    logic [6:0] out_height;
    logic [6:0] out_width;
    logic [3:0] stride_rows;
    logic [3:0] stride_cols;
    logic [3:0] dilation_rows;
    logic [3:0] dilation_cols;
    logic [4:0] pad_top;
    logic [4:0] pad_left;
  } cfg_regs_t;

  // Classified command handed from the front to the back
  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         in_channel;
    logic [1:0]         out_map;
    logic [5:0]         row_index;
    logic [5:0]         col_index;
    logic signed [15:0] value;
    logic               oor;
  } cmd_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  localparam int QUEUE_DEPTH = 4;

  function automatic logic signed [39:0] sat40(input logic signed [40:0] v);
    logic signed [39:0] r;
    if (v[40] != v[39]) begin
      r = v[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

// File: src/tcv_ifs.sv
// Valid/ready channel interfaces for items, results and register writes.
// Depends on tcv_pkg for the payload types.
interface tcv_in_if;
  logic               valid;
  logic               ready;
  tcv_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcv_out_if;
  logic               valid;
  logic               ready;
  tcv_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface tcv_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

// File: src/transposed_conv2d_engine_core.sv
// Transposed 2-D convolution engine, scatter-accumulate, one accumulator access per cycle.
// Each element scatters over its OUT_MAPS*KERNEL_ROWS*KERNEL_COLS taps: an in-shape tap is
// a read, a multiply and a write (states TAP, MUL, ACC), and a tap outside the shape is
// skipped. A clear sweeps all OUT_MAPS*OUT_MAX*OUT_MAX accumulators. The back takes a new
// item only once it is idle again, after it is through with the last one.
// Reset (rst_n low, synchronous): registers, then a sweep of all 16384 accumulators at defaults.
module transposed_conv2d_engine_core #(
  parameter int OUT_MAX     = 64,
  parameter int IN_MAX      = 64,
  parameter int KERNEL_ROWS = 3,
  parameter int KERNEL_COLS = 3,
  parameter int IN_CHANNELS = 4,
  parameter int OUT_MAPS    = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  tcv_in_if.sink     in_ch,
  tcv_out_if.source  out_ch,
  tcv_cfg_if.sink    cfg_ch
);

  tcv_pkg::cfg_regs_t    cfg_r;
  tcv_pkg::back_status_t status;
  tcv_pkg::cmd_t         push_data, q_head;
  logic                  push, q_full, q_valid, q_pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{out_height: 7'd1, out_width: 7'd1, stride_rows: 4'd1, stride_cols: 4'd1,
                 dilation_rows: 4'd1, dilation_cols: 4'd1, pad_top: 5'd0, pad_left: 5'd0};
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        tcv_pkg::REG_OUT_HEIGHT:    cfg_r.out_height    <= cfg_ch.wdata[6:0];
        tcv_pkg::REG_OUT_WIDTH:     cfg_r.out_width     <= cfg_ch.wdata[6:0];
        tcv_pkg::REG_STRIDE_ROWS:   cfg_r.stride_rows   <= cfg_ch.wdata[3:0];
        tcv_pkg::REG_STRIDE_COLS:   cfg_r.stride_cols   <= cfg_ch.wdata[3:0];
        tcv_pkg::REG_DILATION_ROWS: cfg_r.dilation_rows <= cfg_ch.wdata[3:0];
        tcv_pkg::REG_DILATION_COLS: cfg_r.dilation_cols <= cfg_ch.wdata[3:0];
        tcv_pkg::REG_PAD_TOP:       cfg_r.pad_top       <= cfg_ch.wdata[4:0];
        tcv_pkg::REG_PAD_LEFT:      cfg_r.pad_left      <= cfg_ch.wdata[4:0];
        default: ;
      endcase
    end
  end

  tcv_front #(
    .OUT_MAX(OUT_MAX), .IN_MAX(IN_MAX), .KERNEL_ROWS(KERNEL_ROWS),
    .KERNEL_COLS(KERNEL_COLS), .IN_CHANNELS(IN_CHANNELS), .OUT_MAPS(OUT_MAPS)
  ) u_front (
    .cfg(cfg_r), .status(status), .q_full(q_full), .in_ch(in_ch),
    .push(push), .push_data(push_data)
  );

  tcv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_data(push_data), .full(q_full),
    .q_valid(q_valid), .q_head(q_head), .q_pop(q_pop)
  );

  tcv_back #(
    .OUT_MAX(OUT_MAX), .KERNEL_ROWS(KERNEL_ROWS), .KERNEL_COLS(KERNEL_COLS),
    .IN_CHANNELS(IN_CHANNELS), .OUT_MAPS(OUT_MAPS)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .status(status), .out_ch(out_ch)
  );

endmodule

// File: src/tcv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: src/tcv_front.sv
// Front end: accepts items, drops those that do nothing, flags reads outside the shape.
// Depends on tcv_pkg and tcv_ifs.
module tcv_front #(
  parameter int OUT_MAX     = 64,
  parameter int IN_MAX      = 64,
  parameter int KERNEL_ROWS = 3,
  parameter int KERNEL_COLS = 3,
  parameter int IN_CHANNELS = 4,
  parameter int OUT_MAPS    = 4
) (
  input  tcv_pkg::cfg_regs_t    cfg,
  input  tcv_pkg::back_status_t status,
  input  logic                  q_full,
  tcv_in_if.sink                in_ch,
  output logic                  push,
  output tcv_pkg::cmd_t         push_data
);

  int  h_lim, w_lim;
  logic keep;
  logic ch_ok, map_ok;

  always_comb begin
    h_lim  = (int'(cfg.out_height) > OUT_MAX) ? OUT_MAX : int'(cfg.out_height);
    w_lim  = (int'(cfg.out_width) > OUT_MAX) ? OUT_MAX : int'(cfg.out_width);
    ch_ok  = int'(in_ch.data.in_channel) < IN_CHANNELS;
    map_ok = int'(in_ch.data.out_map) < OUT_MAPS;
    case (in_ch.data.kind)
      tcv_pkg::KIND_WEIGHT: keep = ch_ok && map_ok &&
                                   (int'(in_ch.data.row_index) < KERNEL_ROWS) &&
                                   (int'(in_ch.data.col_index) < KERNEL_COLS);
      tcv_pkg::KIND_BIAS:   keep = map_ok;
      tcv_pkg::KIND_ELEM:   keep = ch_ok && (int'(in_ch.data.row_index) < IN_MAX) &&
                                   (int'(in_ch.data.col_index) < IN_MAX);
      tcv_pkg::KIND_READ:   keep = 1'b1;
      tcv_pkg::KIND_CLEAR:  keep = 1'b1;
      default:              keep = 1'b0;
    endcase
    push_data.kind       = in_ch.data.kind;
    push_data.in_channel = in_ch.data.in_channel;
    push_data.out_map    = in_ch.data.out_map;
    push_data.row_index  = in_ch.data.row_index;
    push_data.col_index  = in_ch.data.col_index;
    push_data.value      = in_ch.data.value;
    push_data.oor        = !(map_ok && (int'(in_ch.data.row_index) < h_lim) &&
                             (int'(in_ch.data.col_index) < w_lim));
  end

  // hold off while the accumulators are swept after reset
  assign in_ch.ready = !q_full && !status.init_busy;
  assign push        = in_ch.valid && in_ch.ready && keep;

endmodule

// File: src/tcv_queue.sv
// Short command queue between front and back.
// Depends on tcv_pkg.
module tcv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tcv_pkg::cmd_t push_data,
  output logic          full,
  output logic          q_valid,
  output tcv_pkg::cmd_t q_head,
  input  logic          q_pop
);

  localparam int PW = $clog2(tcv_pkg::QUEUE_DEPTH);

  tcv_pkg::cmd_t q_r [tcv_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [PW:0]   count_r;
  logic          do_push, do_pop;

  assign full    = count_r == (PW+1)'(tcv_pkg::QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_head  = q_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: src/tcv_back.sv
// Back end: weight and accumulator memories, bias registers, the tap sequencer
// with its multiply-accumulate, and the result register. Depends on tcv_pkg, tcv_ifs, tcv_ram.
module tcv_back #(
  parameter int OUT_MAX     = 64,
  parameter int KERNEL_ROWS = 3,
  parameter int KERNEL_COLS = 3,
  parameter int IN_CHANNELS = 4,
  parameter int OUT_MAPS    = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcv_pkg::cfg_regs_t    cfg,
  input  logic                  q_valid,
  input  tcv_pkg::cmd_t         q_head,
  output logic                  q_pop,
  output tcv_pkg::back_status_t status,
  tcv_out_if.source             out_ch
);

  localparam int MAP_W = (OUT_MAPS > 1) ? $clog2(OUT_MAPS) : 1;
  localparam int KR_W  = (KERNEL_ROWS > 1) ? $clog2(KERNEL_ROWS) : 1;
  localparam int KC_W  = (KERNEL_COLS > 1) ? $clog2(KERNEL_COLS) : 1;
  localparam int N_W   = IN_CHANNELS * OUT_MAPS * KERNEL_ROWS * KERNEL_COLS;
  localparam int WAW   = (N_W > 1) ? $clog2(N_W) : 1;
  localparam int N_ACC = OUT_MAPS * OUT_MAX * OUT_MAX;
  localparam int AAW   = (N_ACC > 1) ? $clog2(N_ACC) : 1;
  localparam int CW    = 13;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_TAP  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_ACC  = 3'd4;
  localparam logic [2:0] ST_RD   = 3'd5;
  localparam logic [2:0] ST_CLR  = 3'd6;

  logic [2:0]            state_r, state_nxt;
  tcv_pkg::cmd_t         cmd_r;
  logic [MAP_W-1:0]      m_r;
  logic [KR_W-1:0]       kr_r;
  logic [KC_W-1:0]       kc_r;
  logic [AAW-1:0]        clr_addr_r, tap_addr_r;
  logic                  init_r;
  logic signed [31:0]    prod_r;
  logic                  out_valid_r;
  tcv_pkg::out_item_t    out_data_r;
  logic signed [15:0]    bias_r [OUT_MAPS];

  logic                  slot_free, out_set, tap_ok, last_kc, last_kr, last_m, last_tap;
  logic [CW-2:0]         rsum, csum;
  logic [CW-1:0]         orow, ocol, h_lim, w_lim;
  logic [AAW-1:0]        tap_addr, rd_addr;
  logic [WAW-1:0]        w_tap_addr, w_wr_addr;
  logic                  acc_we, acc_re, w_we, w_re;
  logic [AAW-1:0]        acc_waddr, acc_raddr;
  logic signed [39:0]    acc_wdata, acc_rdata;
  logic signed [15:0]    w_rdata, bias_sel;
  logic signed [40:0]    tap_sum, rd_sum;

  // tap position and range check
  always_comb begin
    rsum = (CW-1)'(cmd_r.row_index) * (CW-1)'(cfg.stride_rows) +
           (CW-1)'(kr_r) * (CW-1)'(cfg.dilation_rows);
    csum = (CW-1)'(cmd_r.col_index) * (CW-1)'(cfg.stride_cols) +
           (CW-1)'(kc_r) * (CW-1)'(cfg.dilation_cols);
    orow = {1'b0, rsum} - {{(CW-5){1'b0}}, cfg.pad_top};
    ocol = {1'b0, csum} - {{(CW-5){1'b0}}, cfg.pad_left};
    h_lim = ({{(CW-7){1'b0}}, cfg.out_height} > CW'(OUT_MAX)) ? CW'(OUT_MAX) :
            {{(CW-7){1'b0}}, cfg.out_height};
    w_lim = ({{(CW-7){1'b0}}, cfg.out_width} > CW'(OUT_MAX)) ? CW'(OUT_MAX) :
            {{(CW-7){1'b0}}, cfg.out_width};
    tap_ok = !orow[CW-1] && !ocol[CW-1] && (orow < h_lim) && (ocol < w_lim);
    tap_addr = AAW'((32'(m_r) * OUT_MAX + 32'(orow)) * OUT_MAX + 32'(ocol));
    rd_addr  = AAW'((32'(cmd_r.out_map) * OUT_MAX + 32'(cmd_r.row_index)) * OUT_MAX +
                    32'(cmd_r.col_index));
    w_tap_addr = WAW'(((32'(cmd_r.in_channel) * OUT_MAPS + 32'(m_r)) * KERNEL_ROWS +
                       32'(kr_r)) * KERNEL_COLS + 32'(kc_r));
    w_wr_addr  = WAW'(((32'(cmd_r.in_channel) * OUT_MAPS + 32'(cmd_r.out_map)) *
                       KERNEL_ROWS + 32'(cmd_r.row_index)) * KERNEL_COLS +
                      32'(cmd_r.col_index));
    last_kc  = kc_r == KC_W'(KERNEL_COLS - 1);
    last_kr  = kr_r == KR_W'(KERNEL_ROWS - 1);
    last_m   = m_r == MAP_W'(OUT_MAPS - 1);
    last_tap = last_kc && last_kr && last_m;
    bias_sel = bias_r[MAP_W'(cmd_r.out_map)];
    tap_sum  = {acc_rdata[39], acc_rdata} + {{9{prod_r[31]}}, prod_r};
    rd_sum   = {acc_rdata[39], acc_rdata} + {{10{bias_sel[15]}}, bias_sel, 15'd0};
  end

  assign slot_free = !out_valid_r || out_ch.ready;
  assign out_set   = slot_free && ((state_r == ST_RD) ||
                     (state_r == ST_EXEC && cmd_r.kind == tcv_pkg::KIND_READ && cmd_r.oor));

  // memory port control
  always_comb begin
    acc_we    = 1'b0;
    acc_waddr = tap_addr_r;
    acc_wdata = tcv_pkg::sat40(tap_sum);
    acc_re    = 1'b0;
    acc_raddr = tap_addr;
    w_we      = 1'b0;
    w_re      = 1'b0;
    case (state_r)
      ST_CLR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr_r;
        acc_wdata = '0;
      end
      ST_TAP: begin
        acc_re = tap_ok;
        w_re   = tap_ok;
      end
      ST_ACC: acc_we = 1'b1;
      ST_EXEC: begin
        w_we = cmd_r.kind == tcv_pkg::KIND_WEIGHT;
        if (cmd_r.kind == tcv_pkg::KIND_READ && !cmd_r.oor) begin
          acc_re    = 1'b1;
          acc_raddr = rd_addr;
        end
      end
      default: ;
    endcase
  end

  tcv_ram #(.WIDTH(40), .DEPTH(N_ACC)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .re(acc_re), .raddr(acc_raddr), .rdata(acc_rdata)
  );

  tcv_ram #(.WIDTH(16), .DEPTH(N_W)) u_w_ram (
    .clk(clk), .we(w_we), .waddr(w_wr_addr), .wdata(cmd_r.value),
    .re(w_re), .raddr(w_tap_addr), .rdata(w_rdata)
  );

  assign q_pop = (state_r == ST_IDLE) && q_valid && !init_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_pop) state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (cmd_r.kind)
          tcv_pkg::KIND_ELEM:  state_nxt = ST_TAP;
          tcv_pkg::KIND_CLEAR: state_nxt = ST_CLR;
          tcv_pkg::KIND_READ: begin
            if (!cmd_r.oor)     state_nxt = ST_RD;
            else if (slot_free) state_nxt = ST_IDLE;
          end
          default:             state_nxt = ST_IDLE;
        endcase
      end
      ST_TAP:  state_nxt = tap_ok ? ST_MUL : (last_tap ? ST_IDLE : ST_TAP);
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = last_tap ? ST_IDLE : ST_TAP;
      ST_RD:   if (slot_free) state_nxt = ST_IDLE;
      ST_CLR:  if (clr_addr_r == AAW'(N_ACC - 1)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_head;
    if (state_r == ST_TAP) tap_addr_r <= tap_addr;
    if (state_r == ST_MUL) prod_r <= cmd_r.value * w_rdata;
    if (state_r == ST_RD && slot_free) begin
      out_data_r.result_value <= tcv_pkg::sat40(rd_sum);
      out_data_r.out_of_range <= 1'b0;
    end
    if (state_r == ST_EXEC && cmd_r.kind == tcv_pkg::KIND_READ && cmd_r.oor && slot_free) begin
      out_data_r.result_value <= '0;
      out_data_r.out_of_range <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      init_r      <= 1'b1;
      clr_addr_r  <= '0;
      m_r         <= '0;
      kr_r        <= '0;
      kc_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < OUT_MAPS; i++) bias_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_set) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          m_r  <= '0;
          kr_r <= '0;
          kc_r <= '0;
        end
        ST_EXEC: begin
          if (cmd_r.kind == tcv_pkg::KIND_BIAS) bias_r[MAP_W'(cmd_r.out_map)] <= cmd_r.value;
          if (cmd_r.kind == tcv_pkg::KIND_CLEAR) clr_addr_r <= '0;
        end
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == AAW'(N_ACC - 1)) init_r <= 1'b0;
        end
        default: ;
      endcase
      // advance the tap counters once a tap is skipped or written
      if ((state_r == ST_TAP && !tap_ok) || state_r == ST_ACC) begin
        if (!last_kc) begin
          kc_r <= kc_r + 1'b1;
        end else begin
          kc_r <= '0;
          if (!last_kr) begin
            kr_r <= kr_r + 1'b1;
          end else begin
            kr_r <= '0;
            m_r  <= m_r + 1'b1;
          end
        end
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.data      = out_data_r;
  assign status.init_busy = init_r;

  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n) !(acc_we && acc_re))
    else $error("accumulator read and write in one cycle");
  a_acc_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> ($past(state_r) == ST_MUL))
    else $error("accumulate without a product");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE && !init_r))
    else $error("command taken while busy");
  a_init_clr: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> (state_r == ST_CLR))
    else $error("initial sweep left early");

endmodule
